### rtl/core/hastep_pkg.sv
// hastep_pkg: shared types and codes of the heat automaton stencil step block
// payload structs of both channels, op codes, register indexes, lfsr constants
// depends on nothing
`default_nettype none

package hastep_pkg;

    typedef struct packed {
        logic [1:0]         op;
        logic [11:0]        cell_index;
        logic signed [31:0] temperature_in;
        logic [15:0]        conductivity_in;
        logic               sign_negative_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temperature_out;
        logic [15:0]        conductivity_out;
        logic               sign_negative_out;
    } out_t;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] CFG_GRID_SIDE      = 2'd0;
    localparam logic [1:0] CFG_FLIP_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_LFSR_SEED      = 2'd2;

    localparam logic [6:0]  GRID_SIDE_RESET      = 7'd64;
    localparam logic [15:0] FLIP_THRESHOLD_RESET = 16'd6554;
    localparam logic [15:0] LFSR_SEED_RESET      = 16'd44257;
    localparam logic [15:0] LFSR_TAPS            = 16'hB400;

    localparam logic [7:0] DIVISOR = 8'd81;

    // divide by 81 one 11-bit digit at a time: floor(x * DIV_RECIP / 2^DIV_SHIFT)
    // is exact for every partial dividend below 81 * 2^11
    localparam int          DIV_DIGIT = 11;
    localparam logic [18:0] DIV_RECIP = 19'd414253;
    localparam int          DIV_SHIFT = 25;

endpackage

`default_nettype wire

### rtl/core/heat_automaton_stencil_step.sv
// heat_automaton_stencil_step: two-bank cell grid with load, read and stencil step
// depends on hastep_pkg
//
// A load writes its cell into the current bank; a read result passes the bank read
// register and then the output register, ready stays low while it is in flight, and a
// read waits while an earlier read result is still pending. A step holds ready low while
// the grid is walked over the single read port of the source bank: per cell one center
// read, a walk over all 25 positions of the 5x5 window (the center and outside positions
// included), a drain of the multiply and accumulate stages, the divide by 81 one 11-bit
// digit at a time and a write. There is no clearing pass after reset.
`default_nettype none

module heat_automaton_stencil_step
    import hastep_pkg::*;
#(
    parameter int MAX_SIDE   = 64,
    parameter int TEMP_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int TW    = TEMP_WIDTH;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE + 1) : 1;
    localparam int GW    = (SW > 7) ? SW : 7;
    localparam int MW    = TW + 17;
    localparam int PW    = TW + 22;
    localparam int ACCW  = TW + 27;
    localparam int QW    = ACCW - 26;
    localparam int DCH   = (QW + DIV_DIGIT - 1) / DIV_DIGIT;
    localparam int QPW   = DCH * DIV_DIGIT;
    localparam int TRW   = 7 + DIV_DIGIT;
    localparam int PRW   = TRW + 19;
    localparam int CW    = $clog2(DCH + 1);
    localparam int XW    = ((TW > 32) ? TW : 32) + 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CENTER, ST_NBR, ST_DRAIN, ST_DIV, ST_WRITE
    } state_t;

    function automatic logic [TW-1:0] sat_tw(input logic [XW-1:0] v);
        logic [XW-TW:0] top;
        top = v[XW-1:TW-1];
        if ((&top) || !(|top)) return v[TW-1:0];
        return v[XW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    endfunction

    function automatic logic [31:0] sat_32(input logic [XW-1:0] v);
        logic [XW-32:0] top;
        top = v[XW-1:31];
        if ((&top) || !(|top)) return v[31:0];
        return v[XW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // memories
    logic [MW-1:0] mem_a [DEPTH];
    logic [MW-1:0] mem_b [DEPTH];
    logic [MW-1:0] rdata_a_reg, rdata_b_reg;

    // control and datapath registers
    state_t state_reg;
    logic             cur_bank_reg;
    logic [6:0]       grid_side_reg;
    logic [15:0]      thr_reg;
    logic [15:0]      lfsr_reg;
    logic             rd_pend_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;
    logic [SW-1:0]    row_reg, col_reg;
    logic signed [2:0] dr_reg, dc_reg;
    logic [AW-1:0]    ctr_addr_reg;
    logic             ctr_pend_reg;
    logic [TW-1:0]    tc_reg;
    logic [15:0]      kc_reg;
    logic             sc_reg;
    logic             a_valid_reg, a_near_reg;
    logic             b_valid_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic             neg_reg;
    logic [QPW-1:0]   q_reg;
    logic [6:0]       rem_reg;
    logic [CW-1:0]    div_cnt_reg;

    // grid side in use
    logic [GW-1:0] gs_ext;
    logic [SW-1:0] side;
    logic [2*SW-1:0] side_sq;
    always_comb begin
        gs_ext = GW'(grid_side_reg);
        if (gs_ext == '0) side = SW'(1);
        else if (gs_ext > GW'(MAX_SIDE)) side = SW'(MAX_SIDE);
        else side = SW'(gs_ext);
        side_sq = (2*SW)'(side) * (2*SW)'(side);
    end

    // input decode
    logic s_fire, in_range, load_fire, read_fire, step_fire;
    logic [AW-1:0] cell_addr;
    assign s_ready   = (state_reg == ST_IDLE) && !rd_pend_reg
                       && !(m_valid_reg && (s_data.op == OP_READ));
    assign s_fire    = s_valid && s_ready;
    assign in_range  = 32'(s_data.cell_index) < 32'(side_sq);
    assign load_fire = s_fire && (s_data.op == OP_LOAD) && in_range;
    assign read_fire = s_fire && (s_data.op == OP_READ) && in_range;
    assign step_fire = s_fire && (s_data.op == OP_STEP);
    assign cell_addr = AW'({{AW{1'b0}}, s_data.cell_index});

    // window position
    logic signed [SW+1:0] rr, cc;
    logic win_ok, is_center, near;
    logic [AW-1:0] win_addr;
    logic [2:0] adr, adc;
    always_comb begin
        rr = $signed({2'b00, row_reg}) + $signed({{(SW-1){dr_reg[2]}}, dr_reg});
        cc = $signed({2'b00, col_reg}) + $signed({{(SW-1){dc_reg[2]}}, dc_reg});
        win_ok = !rr[SW+1] && (rr < $signed({2'b00, side}))
                 && !cc[SW+1] && (cc < $signed({2'b00, side}));
        is_center = (dr_reg == 3'sd0) && (dc_reg == 3'sd0);
        adr = dr_reg[2] ? 3'(-dr_reg) : dr_reg;
        adc = dc_reg[2] ? 3'(-dc_reg) : dc_reg;
        near = (adr <= 3'd1) && (adc <= 3'd1);
        win_addr = AW'((2*SW)'(rr[SW-1:0]) * (2*SW)'(side) + (2*SW)'(cc[SW-1:0]));
    end

    logic [MW-1:0] rd_data;
    assign rd_data = cur_bank_reg ? rdata_b_reg : rdata_a_reg;

    logic [AW-1:0] raddr;
    assign raddr = (state_reg == ST_IDLE) ? cell_addr : win_addr;

    // weight and product
    logic [16:0] ksum;
    logic [20:0] w;
    assign ksum = 17'(kc_reg) + 17'(rd_data[16:1]);
    assign w    = a_near_reg ? {ksum, 4'b0000} : (21'(ksum) + {ksum, 3'b000});

    // divider digit step
    logic [TRW-1:0]       trial;
    logic [PRW-1:0]       qprod;
    logic [DIV_DIGIT-1:0] qd;
    logic [TRW-1:0]       qd_mul;
    assign trial  = {rem_reg, q_reg[QPW-1 -: DIV_DIGIT]};
    assign qprod  = PRW'(trial) * PRW'(DIV_RECIP);
    assign qd     = qprod[DIV_SHIFT+DIV_DIGIT-1:DIV_SHIFT];
    assign qd_mul = TRW'(qd) * TRW'(DIVISOR);

    // new cell
    logic [XW-1:0] tc_ext, q_ext, tn;
    logic [TW-1:0] tn_sat;
    logic [15:0]   lfsr_adv;
    logic          flip;
    logic [MW-1:0] step_word;
    always_comb begin
        tc_ext = XW'($signed(tc_reg));
        q_ext  = XW'(q_reg);
        tn     = (neg_reg ^ sc_reg) ? tc_ext - q_ext : tc_ext + q_ext;
        tn_sat = sat_tw(tn);
        lfsr_adv = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 16'h0000);
        flip = lfsr_adv < thr_reg;
        step_word = {tn_sat, kc_reg, sc_reg ^ flip};
    end

    // bank write ports
    logic          wr_step;
    logic          we_a, we_b;
    logic [AW-1:0] waddr;
    logic [MW-1:0] wdata;
    logic [TW-1:0] load_temp;
    assign wr_step   = (state_reg == ST_WRITE);
    assign load_temp = sat_tw(XW'(s_data.temperature_in));
    assign we_a  = (load_fire && !cur_bank_reg) || (wr_step && cur_bank_reg);
    assign we_b  = (load_fire && cur_bank_reg) || (wr_step && !cur_bank_reg);
    assign waddr = wr_step ? ctr_addr_reg : cell_addr;
    assign wdata = wr_step ? step_word
                 : {load_temp, s_data.conductivity_in, s_data.sign_negative_in};

    always_ff @(posedge aclk) begin
        if (we_a) mem_a[waddr] <= wdata;
        rdata_a_reg <= mem_a[raddr];
    end

    always_ff @(posedge aclk) begin
        if (we_b) mem_b[waddr] <= wdata;
        rdata_b_reg <= mem_b[raddr];
    end

    logic [ACCW-1:0] acc_mag;
    assign acc_mag = acc_reg[ACCW-1] ? ACCW'(-acc_reg) : ACCW'(acc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_bank_reg  <= 1'b0;
            grid_side_reg <= GRID_SIDE_RESET;
            thr_reg       <= FLIP_THRESHOLD_RESET;
            lfsr_reg      <= LFSR_SEED_RESET;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            ctr_pend_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_GRID_SIDE:      grid_side_reg <= cfg_data[6:0];
                    CFG_FLIP_THRESHOLD: thr_reg <= cfg_data;
                    CFG_LFSR_SEED:      lfsr_reg <= (cfg_data == '0) ? 16'd1 : cfg_data;
                    default: ;
                endcase
            end

            // read result
            rd_pend_reg <= read_fire;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
                m_data_reg.temperature_out   <= sat_32(XW'($signed(rd_data[MW-1:17])));
                m_data_reg.conductivity_out  <= rd_data[16:1];
                m_data_reg.sign_negative_out <= rd_data[0];
            end

            // center capture
            ctr_pend_reg <= (state_reg == ST_CENTER);
            if (ctr_pend_reg) begin
                tc_reg <= rd_data[MW-1:17];
                kc_reg <= rd_data[16:1];
                sc_reg <= rd_data[0];
            end

            // multiply and accumulate
            a_valid_reg <= (state_reg == ST_NBR) && win_ok && !is_center;
            a_near_reg  <= near;
            b_valid_reg <= a_valid_reg;
            prod_reg    <= PW'($signed(rd_data[MW-1:17])) * $signed({1'b0, w});
            if (state_reg == ST_CENTER) acc_reg <= '0;
            else if (b_valid_reg) acc_reg <= acc_reg + ACCW'(prod_reg);

            unique case (state_reg)
                ST_IDLE: begin
                    if (step_fire) begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        dr_reg    <= 3'sd0;
                        dc_reg    <= 3'sd0;
                        state_reg <= ST_CENTER;
                    end
                end
                ST_CENTER: begin
                    ctr_addr_reg <= win_addr;
                    dr_reg       <= -3'sd2;
                    dc_reg       <= -3'sd2;
                    state_reg    <= ST_NBR;
                end
                ST_NBR: begin
                    if (dc_reg == 3'sd2) begin
                        dc_reg <= -3'sd2;
                        if (dr_reg == 3'sd2) state_reg <= ST_DRAIN;
                        else dr_reg <= dr_reg + 3'sd1;
                    end else begin
                        dc_reg <= dc_reg + 3'sd1;
                    end
                end
                ST_DRAIN: begin
                    if (!a_valid_reg && !b_valid_reg) begin
                        neg_reg     <= acc_reg[ACCW-1];
                        q_reg       <= QPW'(acc_mag[ACCW-1:26]);
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // divide by 81, one 11-bit quotient digit per cycle by reciprocal
                    rem_reg     <= 7'(trial - qd_mul);
                    q_reg       <= {q_reg[QPW-DIV_DIGIT-1:0], qd};
                    div_cnt_reg <= div_cnt_reg + CW'(1);
                    if (div_cnt_reg == CW'(DCH - 1)) state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    lfsr_reg <= lfsr_adv;
                    dr_reg   <= 3'sd0;
                    dc_reg   <= 3'sd0;
                    if (col_reg == side - SW'(1)) begin
                        col_reg <= '0;
                        if (row_reg == side - SW'(1)) begin
                            cur_bank_reg <= !cur_bank_reg;
                            state_reg    <= ST_IDLE;
                        end else begin
                            row_reg   <= row_reg + SW'(1);
                            state_reg <= ST_CENTER;
                        end
                    end else begin
                        col_reg   <= col_reg + SW'(1);
                        state_reg <= ST_CENTER;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
